// File: hw/rtl/tslr_pkg.sv
package tslr_pkg;

    localparam int RING_DEPTH   = 4096;
    localparam int PACKET_WORDS = 10;
    localparam int POS_W        = $clog2(RING_DEPTH);
    localparam int PKT_W        = $clog2(PACKET_WORDS + 1);
    localparam int CNT_W        = POS_W + 1;

    localparam logic [15:0] META_BIT  = 16'h8000;
    localparam logic [15:0] GAP_BIT   = 16'h4000;
    localparam logic [15:0] IVL_BIT   = 16'h1000;
    localparam logic [15:0] TAG_STOP  = 16'h0002;
    localparam logic [15:0] TAG_START = 16'h0003;
    localparam logic [13:0] GAP_MASK  = 14'h3FFF;
    localparam logic [27:0] SECS_MAX  = 28'hFFFFFFF;

    localparam logic [3:0] CMD_SAMPLE = 4'd0;
    localparam logic [3:0] CMD_START  = 4'd1;
    localparam logic [3:0] CMD_STOP   = 4'd2;
    localparam logic [3:0] CMD_IVL    = 4'd3;
    localparam logic [3:0] CMD_CLEAR  = 4'd4;
    localparam logic [3:0] CMD_RCOUNT = 4'd5;
    localparam logic [3:0] CMD_RMIN   = 4'd6;
    localparam logic [3:0] CMD_FETCH  = 4'd7;
    localparam logic [3:0] CMD_USED   = 4'd8;
    localparam logic [3:0] CMD_TICK   = 4'd9;

    function automatic logic [POS_W-1:0] pos_dec(input logic [POS_W-1:0] a);
        pos_dec = (a == '0) ? POS_W'(RING_DEPTH - 1) : a - 1'b1;
    endfunction

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] a);
        pos_inc = (a == POS_W'(RING_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

endpackage

// File: hw/rtl/tagged_sample_log_ring.sv
// tagged sample log ring: temperature log in an overwriting ring memory
// s_axis: one command per transfer; tdata holds command, temperature,
//   elapsed_seconds and argument. cfg: write of current_interval.
// m_axis: one status transfer per command, ten for a fetch while a read
//   window is open; tlast marks the final transfer of a command.
// order: a sample, start, stop, interval tag or tick writes its ring words,
//   if any, then loads the status; a clear sweeps the whole ring, one word a
//   cycle, plus a start tag while recording;
//   count used and read by minutes walk back one ring word at a time
//   through the single memory read port, a read and a check state per word
//   (a gap tag adds a pair state); a fetch reads, loads and shows each word.
// one command is worked on at a time; s_axis_tready is low while busy.
// reset clears the flags and positions; the whole ring is swept to zero
// after reset before the first command is taken.
// when the receiver stalls the status register holds and the block waits.
module tagged_sample_log_ring
    import tslr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[3:0], temperature[18:4], elapsed_seconds[42:19], argument[58:43]
    input  logic [63:0] s_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // data_word[15:0], window_done[16], window_newest[28:17],
    // window_oldest[40:29], used_count[53:41], seconds_since_sample[81:54],
    // recording_on[82], reading_on[83]
    output logic [87:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_PUSH  = 4'd2;
    localparam logic [3:0] ST_CLEAR = 4'd3;
    localparam logic [3:0] ST_CRD   = 4'd4;
    localparam logic [3:0] ST_CCHK  = 4'd5;
    localparam logic [3:0] ST_WRD   = 4'd6;
    localparam logic [3:0] ST_WCHK  = 4'd7;
    localparam logic [3:0] ST_WPAIR = 4'd8;
    localparam logic [3:0] ST_FRD   = 4'd9;
    localparam logic [3:0] ST_FOUT  = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [15:0] ring_mem [RING_DEPTH];
    logic [15:0] rd_data;
    logic        we;
    logic [POS_W-1:0] waddr, raddr;
    logic [15:0] wdata;

    // ring memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            ring_mem[waddr] <= wdata;
        rd_data <= ring_mem[raddr];
    end

    logic [3:0]       state_reg, state_next;
    logic [POS_W-1:0] wpos_reg, wpos_next, rnext_reg, rnext_next, rlast_reg, rlast_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             rec_reg, rec_next, gap_reg, gap_next, rdg_reg, rdg_next;
    logic [27:0]      secs_reg, secs_next;
    logic [11:0]      ivl_reg, ivl_next, cur_ivl_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [34:0]      rem_reg, rem_next;   // signed remaining seconds
    logic [15:0]      q_reg [3];
    logic [15:0]      q_next [3];
    logic [1:0]       qn_reg, qn_next, qi_reg, qi_next;
    logic [PKT_W-1:0] k_reg, k_next;
    logic             done_reg, done_next;
    logic [15:0]      word_reg, word_next;
    logic [12:0]      used_reg, used_next;
    logic             ov_reg, ov_next, ol_reg, ol_next;
    logic             fdone_reg, fdone_next;

    logic [3:0]  cmd;
    logic [14:0] temp;
    logic [23:0] elapsed;
    logic [15:0] arg;
    logic [28:0] sum;
    logic [27:0] sat;
    logic        s_fire;
    logic [POS_W-1:0] wdec;
    logic [27:0] pair;
    logic [POS_W-1:0] fdist;

    assign cmd     = s_axis_tdata[3:0];
    assign temp    = s_axis_tdata[18:4];
    assign elapsed = s_axis_tdata[42:19];
    assign arg     = s_axis_tdata[58:43];
    assign sum     = {1'b0, secs_reg} + {5'd0, elapsed};
    assign sat     = (sum > {1'b0, SECS_MAX}) ? SECS_MAX : sum[27:0];
    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign wdec    = pos_dec(wpos_reg);
    // newer gap tag holds the high part
    assign pair    = {word_reg[13:0], rd_data[13:0]};
    // words left before the oldest address of the window
    assign fdist   = rnext_reg - rlast_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        wpos_next = wpos_reg; rnext_next = rnext_reg; rlast_next = rlast_reg;
        pos_next = pos_reg; rec_next = rec_reg; gap_next = gap_reg; rdg_next = rdg_reg;
        secs_next = secs_reg; ivl_next = ivl_reg; cnt_next = cnt_reg; rem_next = rem_reg;
        q_next = q_reg; qn_next = qn_reg; qi_next = qi_reg; k_next = k_reg;
        done_next = done_reg; word_next = word_reg;
        used_next = used_reg; ov_next = ov_reg; ol_next = ol_reg; fdone_next = fdone_reg;
        we = 1'b0; waddr = wpos_reg; wdata = q_reg[qi_reg]; raddr = pos_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                we = 1'b1; waddr = pos_reg; wdata = '0;
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_W'(RING_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                used_next = '0; word_next = '0; ol_next = 1'b1; fdone_next = 1'b0;
                qn_next = '0; qi_next = '0;
                if (s_fire)
                begin
                    state_next = ST_OUT;
                    case (cmd)
                        CMD_SAMPLE:
                        begin
                            if (rec_reg)
                            begin
                                state_next = ST_PUSH;
                                if (gap_reg)
                                begin
                                    gap_next = 1'b0;
                                    if (sat > 28'(GAP_MASK))
                                    begin
                                        q_next[0] = META_BIT | GAP_BIT | {2'b0, sat[13:0]};
                                        q_next[1] = META_BIT | GAP_BIT | {2'b0, sat[27:14]};
                                        q_next[2] = {1'b0, temp};
                                        qn_next = 2'd3;
                                    end
                                    else
                                    begin
                                        q_next[0] = META_BIT | GAP_BIT | {2'b0, sat[13:0]};
                                        q_next[1] = {1'b0, temp};
                                        qn_next = 2'd2;
                                    end
                                end
                                else
                                begin
                                    q_next[0] = {1'b0, temp};
                                    qn_next = 2'd1;
                                end
                                secs_next = '0;
                            end
                            else
                                secs_next = sat;
                        end
                        CMD_START:
                        begin
                            rec_next = 1'b1; gap_next = 1'b1;
                            q_next[0] = META_BIT | TAG_START; qn_next = 2'd1;
                            state_next = ST_PUSH;
                        end
                        CMD_STOP:
                            if (rec_reg)
                            begin
                                rec_next = 1'b0;
                                q_next[0] = META_BIT | TAG_STOP; qn_next = 2'd1;
                                state_next = ST_PUSH;
                            end
                        CMD_IVL:
                        begin
                            q_next[0] = META_BIT | IVL_BIT | {4'd0, arg[11:0]};
                            qn_next = 2'd1; state_next = ST_PUSH;
                        end
                        CMD_CLEAR:
                        begin
                            cnt_next = '0; state_next = ST_CLEAR;
                        end
                        CMD_RCOUNT:
                        begin
                            if (arg >= 16'(RING_DEPTH))
                                rlast_next = pos_inc(wpos_reg);
                            else
                                rlast_next = wpos_reg - arg[POS_W-1:0];
                            rnext_next = wdec; rdg_next = 1'b1;
                        end
                        CMD_RMIN:
                        begin
                            rnext_next = wdec; rdg_next = 1'b1;
                            rem_next = 35'({arg, 6'd0} - {2'b0, arg, 2'd0}) - 35'(secs_reg);
                            pos_next = wdec; cnt_next = '0; ivl_next = cur_ivl_reg;
                            state_next = ST_WRD;
                        end
                        CMD_FETCH:
                            if (rdg_reg)
                            begin
                                // the window closes within this packet
                                rdg_next = !(fdist < POS_W'(PACKET_WORDS));
                                k_next = '0; done_next = 1'b0; state_next = ST_FRD;
                            end
                        CMD_USED:
                        begin
                            pos_next = wdec; cnt_next = '0; state_next = ST_CRD;
                        end
                        CMD_TICK: secs_next = sat;
                        default: ;
                    endcase
                end
            end
            ST_PUSH:
            begin
                we = 1'b1;
                wpos_next = pos_inc(wpos_reg);
                qi_next = qi_reg + 1'b1;
                if (qi_reg + 1'b1 == qn_reg)
                    state_next = ST_OUT;
            end
            ST_CLEAR:
            begin
                we = 1'b1; wdata = META_BIT;
                wpos_next = pos_inc(wpos_reg);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RING_DEPTH - 1))
                begin
                    if (rec_reg)
                    begin
                        gap_next = 1'b1; q_next[0] = META_BIT | TAG_START;
                        qn_next = 2'd1; qi_next = '0; state_next = ST_PUSH;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_CRD:
            begin
                if (cnt_reg == CNT_W'(RING_DEPTH))
                begin
                    used_next = 13'(cnt_reg); state_next = ST_OUT;
                end
                else
                    state_next = ST_CCHK;
            end
            ST_CCHK:
            begin
                if (rd_data == META_BIT)
                begin
                    used_next = 13'(cnt_reg); state_next = ST_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1; pos_next = pos_dec(pos_reg);
                    state_next = ST_CRD;
                end
            end
            ST_WRD:
            begin
                if ($signed(rem_reg) <= 0)
                begin
                    rlast_next = pos_inc(pos_reg); state_next = ST_OUT;
                end
                else
                    state_next = ST_WCHK;
            end
            ST_WCHK:
            begin
                state_next = ST_WRD;
                if (rd_data[15])
                begin
                    if (rd_data[14])
                    begin
                        // look at the older word for a second gap tag
                        word_next = rd_data; pos_next = pos_dec(pos_reg);
                        raddr = pos_dec(pos_reg);
                        state_next = ST_WPAIR;
                    end
                    else if (rd_data[12])
                        ivl_next = rd_data[11:0];
                    else if (rd_data == META_BIT)
                    begin
                        rlast_next = pos_inc(pos_reg); state_next = ST_OUT;
                    end
                end
                else
                    rem_next = rem_reg - 35'(ivl_reg);
                if (state_next == ST_WRD)
                begin
                    pos_next = pos_dec(pos_reg);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 >= CNT_W'(RING_DEPTH))
                    begin
                        rlast_next = wpos_reg; state_next = ST_OUT;
                    end
                end
            end
            ST_WPAIR:
            begin
                // pos_reg already points at the older word
                state_next = ST_WRD;
                word_next = '0;
                if (rd_data[15:14] == 2'b11)
                begin
                    rem_next = rem_reg - 35'(pair);
                    pos_next = pos_dec(pos_reg);
                    cnt_next = cnt_reg + 2'd2;
                    if (cnt_reg + 2'd2 >= CNT_W'(RING_DEPTH))
                    begin
                        rlast_next = wpos_reg; state_next = ST_OUT;
                    end
                end
                else
                begin
                    rem_next = rem_reg - 35'(word_reg[13:0]);
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg + 1'b1 >= CNT_W'(RING_DEPTH))
                    begin
                        rlast_next = wpos_reg; state_next = ST_OUT;
                    end
                end
            end
            ST_FRD:
            begin
                raddr = rnext_reg;
                if (rnext_reg == rlast_reg)
                    done_next = 1'b1;
                fdone_next = (rnext_reg == rlast_reg) || done_reg;
                rnext_next = pos_dec(rnext_reg);
                state_next = ST_FOUT;
            end
            ST_FOUT:
            begin
                word_next = rd_data;
                ol_next = (k_reg == PKT_W'(PACKET_WORDS - 1));
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // output register loaded here, then wait for the transfer
            end
            default: state_next = ST_IDLE;
        endcase
        if (ov_reg && m_axis_tready)
            ov_next = 1'b0;
        if (state_reg == ST_OUT && !ov_reg)
        begin
            ov_next = 1'b1;
        end
        if (state_reg == ST_OUT && ov_reg && m_axis_tready)
        begin
            if (!ol_reg)
            begin
                k_next = k_reg + 1'b1; state_next = ST_FRD;
            end
            else
                state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT; wpos_reg <= '0; rnext_reg <= '0; rlast_reg <= '0;
            pos_reg <= '0; rec_reg <= 1'b0; gap_reg <= 1'b0; rdg_reg <= 1'b0;
            secs_reg <= '0; cur_ivl_reg <= 12'd60; qn_reg <= '0; qi_reg <= '0;
            ov_reg <= 1'b0; k_reg <= '0; done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; wpos_reg <= wpos_next; rnext_reg <= rnext_next;
            rlast_reg <= rlast_next; pos_reg <= pos_next; rec_reg <= rec_next;
            gap_reg <= gap_next; rdg_reg <= rdg_next; secs_reg <= secs_next;
            qn_reg <= qn_next; qi_reg <= qi_next; ov_reg <= ov_next;
            k_reg <= k_next; done_reg <= done_next;
            if (cfg_valid && cfg_ready)
                cur_ivl_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ivl_reg <= ivl_next; cnt_reg <= cnt_next; rem_reg <= rem_next;
        q_reg <= q_next; word_reg <= word_next; used_reg <= used_next;
        ol_reg <= ol_next; fdone_reg <= fdone_next;
    end

    // status fields come straight from state while the transfer is shown
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tdata  = {4'd0, rdg_reg, rec_reg, secs_reg, used_reg, rlast_reg,
                            rnext_reg, fdone_reg, word_reg};

    // assertions
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("command taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("status dropped under stall");
    a_no_write_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !we)
        else $error("ring written while status shown");
    a_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PUSH) |-> (qi_reg < qn_reg))
        else $error("push queue overrun");

endmodule

// File: tb/tb_tagged_sample_log_ring.sv
module tb_tagged_sample_log_ring;
    import tslr_pkg::*;

    localparam logic [27:0] SECS_SAT   = 28'hFFFFFFF;
    localparam int          IDLE_LIMIT = 60000;
    localparam int          HOLD_LEN   = 400;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [14:0] temp;
        logic [23:0] elapsed;
        logic [15:0] arg;
    } cmd_item_t;

    typedef struct packed {
        logic [15:0] word;
        logic        last;
        logic        done;
        logic [11:0] newest;
        logic [11:0] oldest;
        logic [12:0] used;
        logic [27:0] secs;
        logic        rec;
        logic        rd;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_data;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    tagged_sample_log_ring uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow copy of the log state
    logic [15:0] shadow_ring [RING_DEPTH];
    logic [11:0] sh_wp;
    logic        sh_rec;
    logic        sh_gap;
    logic [27:0] sh_secs;
    logic [11:0] sh_next;
    logic [11:0] sh_oldest;
    logic        sh_rd;
    logic [11:0] sh_ivl;

    cmd_item_t pending_cmds [$];
    status_t   status_due [$];
    cmd_item_t cur_cmd;
    int        errors;
    int        n_in;
    int        clears;
    logic      calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void log_push(input logic [15:0] w);
        shadow_ring[sh_wp] = w;
        sh_wp = sh_wp + 12'd1;
    endfunction

    function automatic void secs_add(input logic [23:0] e);
        logic [28:0] t;
        t = {1'b0, sh_secs} + 29'(e);
        sh_secs = (t > 29'(SECS_SAT)) ? SECS_SAT : t[27:0];
    endfunction

    function automatic void start_rec();
        sh_rec = 1'b1;
        sh_gap = 1'b1;
        log_push(META_BIT | TAG_START);
    endfunction

    // time walk back from the newest word
    function automatic logic [11:0] minutes_window(input logic [15:0] minutes);
        longint      rem;
        logic [11:0] pos;
        logic [11:0] older;
        logic [15:0] v;
        logic [15:0] pk;
        longint      el;
        int          visited;
        logic [11:0] ivl;
        rem = longint'(minutes) * 60 - longint'(sh_secs);
        pos = sh_wp - 12'd1;
        visited = 0;
        ivl = sh_ivl;
        while (rem > 0)
        begin
            v = shadow_ring[pos];
            if (v[15])
            begin
                if (v[14])
                begin
                    el = longint'(v[13:0]);
                    older = pos - 12'd1;
                    pk = shadow_ring[older];
                    if (pk[15:14] == 2'b11)
                    begin
                        el = (el << 14) | longint'(pk[13:0]);
                        pos = older;
                        visited++;
                    end
                    rem -= el;
                end
                else if (v[12])
                    ivl = v[11:0];
                else if (v == META_BIT)
                    return pos + 12'd1;
            end
            else
                rem -= longint'(ivl);
            pos = pos - 12'd1;
            visited++;
            if (visited >= RING_DEPTH)
                return sh_wp;
        end
        return pos + 12'd1;
    endfunction

    function automatic logic [12:0] words_in_use();
        logic [11:0] pos;
        int          used;
        pos = sh_wp - 12'd1;
        used = 0;
        while (used < RING_DEPTH && shadow_ring[pos] != META_BIT)
        begin
            used++;
            pos = pos - 12'd1;
        end
        return 13'(used);
    endfunction

    function automatic status_t status_of(input logic [15:0] w, input logic last,
                                          input logic done, input logic [12:0] used);
        status_t s;
        s.word = w;
        s.last = last;
        s.done = done;
        s.newest = sh_next;
        s.oldest = sh_oldest;
        s.used = used;
        s.secs = sh_secs;
        s.rec = sh_rec;
        s.rd = sh_rd;
        return s;
    endfunction

    // apply one command to the shadow state and queue its status transfers
    function automatic void apply_command(input cmd_item_t c);
        status_t     pkt [PACKET_WORDS];
        logic        done;
        logic [12:0] used;
        logic [15:0] w;
        used = '0;
        case (c.cmd)
            CMD_SAMPLE:
            begin
                if (sh_rec)
                begin
                    if (sh_gap)
                    begin
                        sh_gap = 1'b0;
                        secs_add(c.elapsed);
                        if (sh_secs > 28'(GAP_MASK))
                        begin
                            log_push(META_BIT | GAP_BIT | 16'(sh_secs[13:0]));
                            log_push(META_BIT | GAP_BIT | 16'(sh_secs[27:14]));
                        end
                        else
                            log_push(META_BIT | GAP_BIT | 16'(sh_secs[13:0]));
                    end
                    sh_secs = '0;
                    log_push({1'b0, c.temp});
                end
                else
                    secs_add(c.elapsed);
            end
            CMD_START: start_rec();
            CMD_STOP:
            begin
                if (sh_rec)
                begin
                    sh_rec = 1'b0;
                    log_push(META_BIT | TAG_STOP);
                end
            end
            CMD_IVL: log_push(META_BIT | IVL_BIT | {4'd0, c.arg[11:0]});
            CMD_CLEAR:
            begin
                for (int i = 0; i < RING_DEPTH; i++)
                    shadow_ring[i] = META_BIT;
                if (sh_rec)
                    start_rec();
            end
            CMD_RCOUNT:
            begin
                sh_oldest = sh_wp - ((c.arg >= RING_DEPTH) ? 12'(RING_DEPTH - 1) : c.arg[11:0]);
                sh_next = sh_wp - 12'd1;
                sh_rd = 1'b1;
            end
            CMD_RMIN:
            begin
                sh_next = sh_wp - 12'd1;
                sh_oldest = minutes_window(c.arg);
                sh_rd = 1'b1;
            end
            CMD_FETCH:
            begin
                if (sh_rd)
                begin
                    done = 1'b0;
                    for (int k = 0; k < PACKET_WORDS; k++)
                    begin
                        w = shadow_ring[sh_next];
                        if (sh_next == sh_oldest)
                            done = 1'b1;
                        sh_next = sh_next - 12'd1;
                        pkt[k] = status_of(w, k == PACKET_WORDS - 1, done, '0);
                    end
                    if (done)
                        sh_rd = 1'b0;
                    for (int k = 0; k < PACKET_WORDS; k++)
                    begin
                        pkt[k].rd = sh_rd;
                        status_due.push_back(pkt[k]);
                    end
                    return;
                end
            end
            CMD_USED: used = words_in_use();
            CMD_TICK: secs_add(c.elapsed);
            default: ;
        endcase
        status_due.push_back(status_of('0, 1'b1, 1'b0, used));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic cmd_item_t mk(input logic [3:0] cmd, input logic [14:0] temp,
                                     input logic [23:0] el, input logic [15:0] arg);
        cmd_item_t c;
        c.cmd = cmd;
        c.temp = temp;
        c.elapsed = el;
        c.arg = arg;
        return c;
    endfunction

    function automatic logic [23:0] rand_elapsed();
        if ($urandom_range(0, 9) == 0)
            return 24'($urandom);
        return 24'($urandom_range(0, 200));
    endfunction

    // command driver
    int drv_gap;
    always @(posedge clk)
    begin
        logic nv;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            drv_gap = 0;
        end
        else
        begin
            nv = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_command(cur_cmd);
                n_in++;
                if ($urandom_range(0, 199) == 0)
                    calm = ~calm;
                drv_gap = pick_gap();
                nv = 1'b0;
            end
            if (!nv)
            begin
                if (drv_gap > 0)
                    drv_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_axis_tdata <= {5'd0, cur_cmd.arg, cur_cmd.elapsed,
                                     cur_cmd.temp, cur_cmd.cmd};
                    nv = 1'b1;
                end
            end
            s_axis_tvalid <= nv;
        end
    end

    // status receiver with random stalls and one long hold-off
    int   rcv_stall;
    int   hold_cnt;
    logic held;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rcv_stall = 0;
            hold_cnt = 0;
            held = 1'b0;
        end
        else
        begin
            if (!held && n_in >= 150)
            begin
                held = 1'b1;
                hold_cnt = HOLD_LEN;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                m_axis_tready <= 1'b0;
            end
            else if (rcv_stall > 0)
            begin
                rcv_stall--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    rcv_stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 50)
                                                              : $urandom_range(1, 3);
            end
        end
    end

    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
            errors++;
        end
    endtask

    // status checker and watchdog
    int idle_cycles;
    always @(posedge clk)
    begin
        status_t e;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout", $time);
                $display("Verification failed");
                $finish;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected transfer, expected none actual %0h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = status_due.pop_front();
                    check_field("data_word", e.word, m_axis_tdata[15:0]);
                    check_field("last_word", e.last, m_axis_tlast);
                    check_field("window_done", e.done, m_axis_tdata[16]);
                    check_field("window_newest", e.newest, m_axis_tdata[28:17]);
                    check_field("window_oldest", e.oldest, m_axis_tdata[40:29]);
                    check_field("used_count", e.used, m_axis_tdata[53:41]);
                    check_field("seconds_since_sample", e.secs, m_axis_tdata[81:54]);
                    check_field("recording_on", e.rec, m_axis_tdata[82]);
                    check_field("reading_on", e.rd, m_axis_tdata[83]);
                end
            end
        end
    end

    task automatic wait_idle();
        while (pending_cmds.size() > 0 || s_axis_tvalid || status_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_interval(input logic [11:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        sh_ivl = v;
        cfg_valid <= 1'b0;
    endtask

    // random commands, mostly well-formed recording and read sequences
    task automatic fill_random(input int n);
        int r;
        int cnt;
        cnt = 0;
        while (cnt < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                pending_cmds.push_back(mk(CMD_SAMPLE, 15'($urandom), rand_elapsed(),
                                          16'($urandom)));
            else if (r < 40)
                pending_cmds.push_back(mk(CMD_TICK, 15'($urandom), rand_elapsed(),
                                          16'($urandom)));
            else if (r < 46)
                pending_cmds.push_back(mk(CMD_START, 15'($urandom), 24'($urandom),
                                          16'($urandom)));
            else if (r < 52)
                pending_cmds.push_back(mk(CMD_STOP, 15'($urandom), 24'($urandom),
                                          16'($urandom)));
            else if (r < 57)
                pending_cmds.push_back(mk(CMD_IVL, 15'($urandom), 24'($urandom),
                                          ($urandom_range(0, 1) ? 16'($urandom)
                                                                : 16'($urandom_range(0, 90)))));
            else if (r < 62 || r < 68)
            begin
                if (r < 62)
                    pending_cmds.push_back(mk(CMD_RCOUNT, 15'($urandom), 24'($urandom),
                                              ($urandom_range(0, 9) < 3 ? 16'($urandom)
                                                                      : 16'($urandom_range(0, 40)))));
                else
                    pending_cmds.push_back(mk(CMD_RMIN, 15'($urandom), 24'($urandom),
                                              ($urandom_range(0, 9) == 0 ? 16'($urandom)
                                                                       : 16'($urandom_range(0, 30)))));
                repeat ($urandom_range(1, 4))
                begin
                    pending_cmds.push_back(mk(CMD_FETCH, 15'($urandom), 24'($urandom),
                                              16'($urandom)));
                    cnt++;
                end
            end
            else if (r < 76)
                pending_cmds.push_back(mk(CMD_FETCH, 15'($urandom), 24'($urandom),
                                          16'($urandom)));
            else if (r < 81)
                pending_cmds.push_back(mk(CMD_USED, 15'($urandom), 24'($urandom),
                                          16'($urandom)));
            else if (r < 84)
                pending_cmds.push_back(mk(4'($urandom_range(10, 15)), 15'($urandom),
                                          24'($urandom), 16'($urandom)));
            else if (r < 85 && clears < 4)
            begin
                clears++;
                pending_cmds.push_back(mk(CMD_CLEAR, 15'($urandom), 24'($urandom),
                                          16'($urandom)));
            end
            else if (r < 86)
            begin
                // run the seconds counter into saturation
                repeat (17)
                begin
                    pending_cmds.push_back(mk(CMD_TICK, '0, 24'hFFFFFF, '0));
                    cnt++;
                end
            end
            else
                pending_cmds.push_back(mk(CMD_SAMPLE, 15'($urandom), rand_elapsed(),
                                          16'($urandom)));
            cnt++;
        end
    endtask

    logic [11:0] intervals [4];

    initial
    begin
        errors = 0;
        n_in = 0;
        clears = 0;
        calm = 1'b0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < RING_DEPTH; i++)
            shadow_ring[i] = '0;
        sh_wp = '0;
        sh_rec = 1'b0;
        sh_gap = 1'b0;
        sh_secs = '0;
        sh_next = '0;
        sh_oldest = '0;
        sh_rd = 1'b0;
        sh_ivl = 12'd60;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed commands
        pending_cmds.push_back(mk(CMD_FETCH, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_SAMPLE, 15'h7FFF, 24'hFFFFFF, 16'hFFFF));
        pending_cmds.push_back(mk(CMD_STOP, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_START, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_SAMPLE, 15'h4000, 24'hFFFFFF, '0));
        pending_cmds.push_back(mk(CMD_SAMPLE, 15'h3FFF, 24'd5, '0));
        pending_cmds.push_back(mk(CMD_IVL, '0, '0, 16'hFFFF));
        pending_cmds.push_back(mk(CMD_SAMPLE, 15'h0000, '0, '0));
        pending_cmds.push_back(mk(CMD_STOP, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_STOP, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_TICK, '0, 24'd100, '0));
        pending_cmds.push_back(mk(CMD_START, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_SAMPLE, 15'h1234, 24'd10, '0));
        pending_cmds.push_back(mk(CMD_RCOUNT, '0, '0, 16'd0));
        pending_cmds.push_back(mk(CMD_FETCH, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_RCOUNT, '0, '0, 16'hFFFF));
        pending_cmds.push_back(mk(CMD_FETCH, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_RMIN, '0, '0, 16'd0));
        pending_cmds.push_back(mk(CMD_RMIN, '0, '0, 16'd3));
        pending_cmds.push_back(mk(CMD_FETCH, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_USED, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_CLEAR, '0, '0, '0));
        pending_cmds.push_back(mk(CMD_USED, '0, '0, '0));
        pending_cmds.push_back(mk(4'd15, 15'h7FFF, 24'hFFFFFF, 16'hFFFF));
        pending_cmds.push_back(mk(4'd10, '0, '0, '0));
        clears = 1;
        fill_random(95);

        intervals[0] = 12'hFFF;
        intervals[1] = 12'd1;
        intervals[2] = 12'd0;
        intervals[3] = 12'($urandom_range(2, 300));
        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            write_interval(intervals[p]);
            fill_random(90);
        end

        wait_idle();
        repeat (100) @(posedge clk);
        if (status_due.size() != 0)
        begin
            $display("%0t: %0d status transfers never arrived", $time, status_due.size());
            errors++;
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/tslr_pkg.sv
hw/rtl/tagged_sample_log_ring.sv
tb/tb_tagged_sample_log_ring.sv
